/* rtl/orle_pkg.sv */
// Shared types, codes and the code normalising function for the ordered record list engine.
`timescale 1ns / 1ps

package orle_pkg;

	localparam int unsigned DEPTH_DEF     = 64;
	localparam int unsigned KEY_CHARS_DEF = 10;
	localparam int unsigned CODE_BYTES    = 10;

	typedef enum logic [1:0] {
		MODE_INS_HEAD = 2'd0,
		MODE_APPEND   = 2'd1,
		MODE_DELETE   = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_SHR  = 2'd1,
		OP_SHL  = 2'd2,
		OP_WR   = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [47:0] hi;
		logic [31:0] lo;
	} code_t;

	typedef struct packed {
		code_t class_code;
		code_t subject_code;
	} rec_t;

	typedef struct packed {
		cell_op_t op;
		logic     keep;
	} cell_ctl_t;

	typedef struct packed {
		mode_t       mode;
		logic [47:0] class_code_hi;
		logic [31:0] class_code_lo;
		logic [47:0] subject_code_hi;
		logic [31:0] subject_code_lo;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  removed_count;
		logic [6:0]  entry_count;
		logic [47:0] read_class_hi;
		logic [31:0] read_class_lo;
		logic [47:0] read_subject_hi;
		logic [31:0] read_subject_lo;
	} rsp_t;

	// A code ends at its first zero byte and only the first key_chars characters count.
	function automatic code_t norm_code(input logic [47:0] hi, input logic [31:0] lo,
			input int unsigned key_chars);
		logic [79:0] w;
		logic [79:0] r;
		logic        ended;
		logic [7:0]  b;
		code_t       c;
		w     = {hi, lo};
		r     = '0;
		ended = 1'b0;
		for (int unsigned i = 0; i < CODE_BYTES; i++) begin
			b = w[79 - 8 * i -: 8];
			if (b == 8'h00) begin
				ended = 1'b1;
			end
			if (!ended && (i < key_chars)) begin
				r[79 - 8 * i -: 8] = b;
			end
		end
		c.hi = r[79:32];
		c.lo = r[31:0];
		return c;
	endfunction

endpackage

/* rtl/ordered_record_list_engine.sv */
// Top level of the ordered record list engine: chain of record cells and its sequencer.
`timescale 1ns / 1ps
// Insert at head, append and a refused insert finish in S_RUN by registering the response
// once the output register is free. Delete and read first walk every held record once past
// the head cell and then register the response; a read beyond the count skips the walk.
// A new transaction is taken the cycle after the response enters the output register, so no
// new transaction is taken while one is still in progress.
// Reset clears the held count; the record cells are not cleared and only count below it.

module ordered_record_list_engine #(
	parameter int unsigned DEPTH     = orle_pkg::DEPTH_DEF,
	parameter int unsigned KEY_CHARS = orle_pkg::KEY_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  orle_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output orle_pkg::rsp_t rsp
);
	import orle_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);

	cell_ctl_t     ctl;
	logic [IW-1:0] wr_idx;
	rec_t          new_rec;
	rec_t          cell_rec [DEPTH];

	orle_ctrl #(
		.DEPTH     (DEPTH),
		.KEY_CHARS (KEY_CHARS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head_rec  (cell_rec[0]),
		.ctl       (ctl),
		.wr_idx    (wr_idx),
		.new_rec   (new_rec)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t left_rec;
		rec_t right_rec;

		if (i == 0) begin : g_first
			assign left_rec = new_rec;
		end else begin : g_inner_l
			assign left_rec = cell_rec[i - 1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_rec = cell_rec[i];
		end else begin : g_inner_r
			assign right_rec = cell_rec[i + 1];
		end

		orle_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_idx    (wr_idx),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.head_rec  (cell_rec[0]),
			.rec       (cell_rec[i])
		);
	end

endmodule

/* rtl/orle_cell.sv */
// One cell of the record chain: holds one record and moves it to or from its neighbours.
`timescale 1ns / 1ps

module orle_cell #(
	parameter int unsigned DEPTH = orle_pkg::DEPTH_DEF,
	parameter int unsigned IDX   = 0
) (
	input  logic                     clk,
	input  orle_pkg::cell_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  orle_pkg::rec_t           new_rec,
	input  orle_pkg::rec_t           left_rec,
	input  orle_pkg::rec_t           right_rec,
	input  orle_pkg::rec_t           head_rec,
	output orle_pkg::rec_t           rec
);
	import orle_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);

	logic hit;
	rec_t rec_q;

	assign hit = (wr_idx == IW'(IDX));
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: rec_q <= rec_q;
			OP_SHR:  rec_q <= left_rec;
			// During a walk the head record re-enters at the end of the kept run.
			OP_SHL:  rec_q <= (hit && ctl.keep) ? head_rec : right_rec;
			OP_WR:   rec_q <= hit ? new_rec : rec_q;
			default: rec_q <= rec_q;
		endcase
	end

endmodule

/* rtl/orle_ctrl.sv */
// Sequencer for the record chain: takes a request, drives the cells and registers the response.
`timescale 1ns / 1ps

module orle_ctrl #(
	parameter int unsigned DEPTH     = orle_pkg::DEPTH_DEF,
	parameter int unsigned KEY_CHARS = orle_pkg::KEY_CHARS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  orle_pkg::req_t           req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output orle_pkg::rsp_t           rsp,
	input  orle_pkg::rec_t           head_rec,
	output orle_pkg::cell_ctl_t      ctl,
	output logic [$clog2(DEPTH)-1:0] wr_idx,
	output orle_pkg::rec_t           new_rec
);
	import orle_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > 6) ? CW : 6;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t         state_q;
	mode_t          mode_q;
	code_t          key_q;
	code_t          subj_q;
	logic [5:0]     position_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  len_q;
	logic [CW-1:0]  pos_q;
	logic [CW-1:0]  removed_q;
	rec_t           rd_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic           out_free;
	logic           full;
	logic           read_miss;
	logic           walk_done;
	logic           hit;
	logic           emit;
	logic [CW-1:0]  cnt_nx;
	rsp_t           rsp_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign new_rec   = '{class_code: key_q, subject_code: subj_q};

	always_comb begin
		out_free  = !rsp_valid_q || rsp_ready;
		full      = (cnt_q == CW'(DEPTH));
		read_miss = (PW'(position_q) >= PW'(cnt_q));
		walk_done = (pos_q == cnt_q);
		hit       = (head_rec.class_code == key_q);
		ctl.op    = OP_HOLD;
		ctl.keep  = 1'b1;
		wr_idx    = '0;
		emit      = 1'b0;
		cnt_nx    = cnt_q;
		if (state_q == S_RUN) begin
			unique case (mode_q)
				MODE_INS_HEAD: begin
					emit = out_free;
					if (out_free && !full) begin
						ctl.op = OP_SHR;
						cnt_nx = cnt_q + CW'(1);
					end
				end
				MODE_APPEND: begin
					emit = out_free;
					if (out_free && !full) begin
						ctl.op = OP_WR;
						wr_idx = IW'(cnt_q);
						cnt_nx = cnt_q + CW'(1);
					end
				end
				MODE_DELETE, MODE_READ: begin
					if ((mode_q == MODE_READ) && read_miss) begin
						emit = out_free;
					end else if (!walk_done) begin
						// Walk the held records past the head once; kept ones close up at the end.
						ctl.op   = OP_SHL;
						ctl.keep = (mode_q == MODE_READ) || !hit;
						wr_idx   = IW'(len_q - CW'(1));
					end else begin
						emit = out_free;
					end
					if (mode_q == MODE_DELETE) begin
						cnt_nx = len_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp_d                 = '0;
		rsp_d.entry_count     = 7'(cnt_nx);
		unique case (mode_q)
			MODE_INS_HEAD, MODE_APPEND: rsp_d.status = full ? ST_FULL : ST_DONE;
			MODE_DELETE: begin
				rsp_d.status        = ST_DONE;
				rsp_d.removed_count = 7'(removed_q);
			end
			MODE_READ: begin
				if (read_miss) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.status          = ST_DONE;
					rsp_d.read_class_hi   = rd_q.class_code.hi;
					rsp_d.read_class_lo   = rd_q.class_code.lo;
					rsp_d.read_subject_hi = rd_q.subject_code.hi;
					rsp_d.read_subject_lo = rd_q.subject_code.lo;
				end
			end
			default: rsp_d.status = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			mode_q      <= MODE_INS_HEAD;
			key_q       <= '0;
			subj_q      <= '0;
			position_q  <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			removed_q   <= '0;
			rd_q        <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !emit) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q     <= req.mode;
						key_q      <= norm_code(req.class_code_hi, req.class_code_lo, KEY_CHARS);
						subj_q     <= norm_code(req.subject_code_hi, req.subject_code_lo,
								KEY_CHARS);
						position_q <= req.position;
						len_q      <= cnt_q;
						pos_q      <= '0;
						removed_q  <= '0;
						state_q    <= S_RUN;
					end
				end
				S_RUN: begin
					if (ctl.op == OP_SHL) begin
						pos_q <= pos_q + CW'(1);
						if (!ctl.keep) begin
							len_q     <= len_q - CW'(1);
							removed_q <= removed_q + CW'(1);
						end
						if (PW'(pos_q) == PW'(position_q)) begin
							rd_q <= head_rec;
						end
					end
					if (emit) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= rsp_d;
						cnt_q       <= cnt_nx;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(cnt_q) <= (CW + 1)'(DEPTH))
		else $error("held count exceeds table depth");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (ctl.op == OP_HOLD))
		else $error("cells moved while no transaction is in progress");

	a_del_balance: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RUN) && (mode_q == MODE_DELETE)) |->
		((CW + 1)'(len_q) + (CW + 1)'(removed_q) == (CW + 1)'(cnt_q)))
		else $error("kept and removed records do not add up to the held count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("pending response transaction was overwritten");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_SHL) |-> (pos_q < cnt_q))
		else $error("walk stepped past the held records");

endmodule
